### rtl/aesk_pkg.sv
// ----------------------------------------------------------------------------
// aesk_pkg
// Shared constants, tables and types for the AES-128 key expansion block.
// ----------------------------------------------------------------------------
package aesk_pkg;

    localparam int ROUND_COUNT     = 10;
    localparam int WORDS_PER_ROUND = 4;

    localparam logic [3:0] ROUND_LAST = 4'(ROUND_COUNT);
    localparam logic [1:0] SLOT_LAST  = 2'(WORDS_PER_ROUND - 1);

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // Round constant for round r (r >= 1), high byte of the word.
    function automatic logic [7:0] rcon(input logic [3:0] round);
        logic [7:0] rc;
        case (round)
            4'd1:    rc = 8'h01;
            4'd2:    rc = 8'h02;
            4'd3:    rc = 8'h04;
            4'd4:    rc = 8'h08;
            4'd5:    rc = 8'h10;
            4'd6:    rc = 8'h20;
            4'd7:    rc = 8'h40;
            4'd8:    rc = 8'h80;
            4'd9:    rc = 8'h1b;
            4'd10:   rc = 8'h36;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

    // Memory port requests from the sequencer to the word store.
    typedef struct packed {
        logic        key_we;
        logic [1:0]  key_addr;
        logic [31:0] key_data;
        logic        win_we;
        logic [1:0]  win_addr;
        logic [31:0] win_data;
        logic        rd_en;
        logic [1:0]  rd_addr;
    } mem_req_t;

endpackage

### rtl/aesk_subword.sv
// ----------------------------------------------------------------------------
// aesk_subword
// RotWord followed by SubWord on one 32-bit schedule word.
// ----------------------------------------------------------------------------
module aesk_subword (
    input  logic [31:0] word_in,
    output logic [31:0] word_out
);

    logic [31:0] rot;

    assign rot = {word_in[23:0], word_in[31:24]};

    assign word_out = {aesk_pkg::SBOX[rot[31:24]], aesk_pkg::SBOX[rot[23:16]],
                       aesk_pkg::SBOX[rot[15:8]],  aesk_pkg::SBOX[rot[7:0]]};

endmodule

### rtl/aesk_store.sv
// ----------------------------------------------------------------------------
// aesk_store
// Key word memory and schedule window memory, both with registered reads.
// ----------------------------------------------------------------------------
module aesk_store (
    input  logic                clk,
    input  aesk_pkg::mem_req_t  req,
    output logic [31:0]         key_rdata,
    output logic [31:0]         win_rdata
);

    logic [31:0] key_mem [4];
    logic [31:0] win_mem [4];

    always_ff @(posedge clk)
    begin
        if (req.key_we)
        begin
            key_mem[req.key_addr] <= req.key_data;
        end
        if (req.win_we)
        begin
            win_mem[req.win_addr] <= req.win_data;
        end
        // hold read data while no read is requested
        if (req.rd_en)
        begin
            key_rdata <= key_mem[req.rd_addr];
            win_rdata <= win_mem[req.rd_addr];
        end
    end

endmodule

### rtl/aes128_key_expansion.sv
// out_valid rises after the request with position 3 is accepted, ST_RUN is entered and the first word is registered.
// Throughput: one schedule word per cycle while out_ready stays high, 44 per key.
// The next key word request is taken in the cycle after the last word is computed.
// Words at positions 0 to 2 are only stored and produce no result.
// Reset clears the sequencer and output valid; key memory is not cleared.
// ----------------------------------------------------------------------------
// aes128_key_expansion
// Collects a 128-bit key and streams its 44-word expanded schedule.
// ----------------------------------------------------------------------------
module aes128_key_expansion (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] key_word,
    input  logic [1:0]  word_position,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] schedule_word,
    output logic [3:0]  round_number,
    output logic [1:0]  word_in_round,
    output logic        last_word
);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t      state_reg, state_next;
    logic [3:0]  round_reg, round_next;
    logic [1:0]  slot_reg, slot_next;
    logic [31:0] prev_reg, prev_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] word_reg, word_next;
    logic [3:0]  oround_reg, oround_next;
    logic [1:0]  oslot_reg, oslot_next;
    logic        olast_reg, olast_next;

    aesk_pkg::mem_req_t req;
    logic [31:0] key_rdata, win_rdata;
    logic [31:0] sub_word;
    logic [31:0] new_word;
    logic        advance, in_fire, is_last;

    aesk_store u_store (
        .clk       (clk),
        .req       (req),
        .key_rdata (key_rdata),
        .win_rdata (win_rdata)
    );

    aesk_subword u_subword (
        .word_in  (prev_reg),
        .word_out (sub_word)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign advance  = (state_reg == ST_RUN) && (!out_valid_reg || out_ready);
    assign is_last  = (round_reg == aesk_pkg::ROUND_LAST) && (slot_reg == aesk_pkg::SLOT_LAST);

    always_comb
    begin
        if (round_reg == 4'd0)
        begin
            new_word = key_rdata;
        end
        else if (slot_reg == 2'd0)
        begin
            new_word = win_rdata ^ sub_word ^ {aesk_pkg::rcon(round_reg), 24'h000000};
        end
        else
        begin
            new_word = win_rdata ^ prev_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        slot_next      = slot_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg && !out_ready;
        word_next      = word_reg;
        oround_next    = oround_reg;
        oslot_next     = oslot_reg;
        olast_next     = olast_reg;

        req          = '0;
        req.key_addr = word_position;
        req.key_data = key_word;
        req.win_addr = slot_reg;
        req.win_data = new_word;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    req.key_we = 1'b1;
                    if (word_position == aesk_pkg::SLOT_LAST)
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = 2'd0;
                        round_next  = 4'd0;
                        slot_next   = 2'd0;
                        state_next  = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    req.win_we     = 1'b1;
                    prev_next      = new_word;
                    out_valid_next = 1'b1;
                    word_next      = new_word;
                    oround_next    = round_reg;
                    oslot_next     = slot_reg;
                    olast_next     = is_last;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // fetch the next slot; never the entry being written
                        slot_next   = slot_reg + 2'd1;
                        round_next  = (slot_reg == aesk_pkg::SLOT_LAST) ? round_reg + 4'd1
                                                                        : round_reg;
                        req.rd_en   = 1'b1;
                        req.rd_addr = slot_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= 4'd0;
            slot_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg   <= prev_next;
        word_reg   <= word_next;
        oround_reg <= oround_next;
        oslot_reg  <= oslot_next;
        olast_reg  <= olast_next;
    end

    assign out_valid     = out_valid_reg;
    assign schedule_word = word_reg;
    assign round_number  = oround_reg;
    assign word_in_round = oslot_reg;
    assign last_word     = olast_reg;

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && olast_reg |->
            (oround_reg == aesk_pkg::ROUND_LAST) && (oslot_reg == aesk_pkg::SLOT_LAST))
        else $error("last_word flagged away from the final schedule word");

    a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (word_position == aesk_pkg::SLOT_LAST) |=> state_reg == ST_RUN)
        else $error("position 3 request did not start a run");

    a_win_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        req.win_we |-> (state_reg == ST_RUN) && !req.key_we)
        else $error("window write outside a run");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= aesk_pkg::ROUND_LAST)
        else $error("round counter out of range");

endmodule
